FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset.
`define GBSL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, reset given by the caller.
`define GBSL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: hw/rtl/gbsl_pkg.sv
// ----------------------------------------------------------------------------
// gbsl_pkg
// Types, constants and codes of the grid Bayes source locator.
// ----------------------------------------------------------------------------
package gbsl_pkg;

  localparam int GRID_DIM = 40;
  localparam int CELLS    = GRID_DIM * GRID_DIM;
  localparam int DIM_W    = $clog2(GRID_DIM);
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int TOTAL_W  = 32 + CELL_AW;

  localparam int OFF_W = DIM_W + 16;
  localparam int DX_W  = DIM_W + 17;
  localparam int SQ_W  = 2 * DX_W;

  localparam int EXP_LAST  = 4096;
  localparam int EXP_DEPTH = EXP_LAST + 1;
  localparam int EXP_AW    = $clog2(EXP_DEPTH);
  localparam logic [63:0] EXP_STEP  = 64'd4278222805;
  localparam logic [31:0] EXP_FIRST = 32'hFFFF_FFFF;

  localparam logic [31:0] INIT_BELIEF = 32'(64'h1_0000_0000 / CELLS);

  // d2/4608 = (d2>>9)/9, d^2/2560 = (d^2>>9)/5, by reciprocal multiply
  localparam logic [15:0] N1_LIMIT = 16'(9 * EXP_DEPTH);
  localparam logic [31:0] N1_RECIP = 32'd58255;
  localparam logic [15:0] N2_LIMIT = 16'(5 * EXP_DEPTH);
  localparam logic [31:0] N2_RECIP = 32'd26215;

  localparam int QUO_W = 33;
  localparam int CNT_W = $clog2(QUO_W + 1);

  localparam logic [1:0] OP_POSE      = 2'd0;
  localparam logic [1:0] OP_READING   = 2'd1;
  localparam logic [1:0] OP_READ_CELL = 2'd2;

  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_NO_POSE   = 2'd1;
  localparam logic [1:0] STAT_COLLAPSED = 2'd2;

  localparam logic [1:0] CFG_CELL_SIZE  = 2'd0;
  localparam logic [1:0] CFG_PEAK_LEVEL = 2'd1;

  localparam logic [6:0] VALUE_MAX = 7'd100;

  typedef enum logic [4:0] {
    ST_INIT_WR, ST_INIT_RND, ST_IDLE, ST_DONE,
    ST_U_OFF, ST_U_SQ, ST_U_N1, ST_U_E1, ST_U_EXPD, ST_U_DIFF,
    ST_U_N2, ST_U_E2, ST_U_LIKE, ST_U_WR,
    ST_N_CHK, ST_N_RD, ST_N_LD, ST_N_DIV, ST_N_WR,
    ST_R_RD, ST_R_LD, ST_R_DIV, ST_R_FIN
  } gbsl_state_t;

  typedef enum logic [4:0] {
    ACT_NONE, ACT_INIT_WR, ACT_INIT_RND, ACT_ACCEPT, ACT_LOAD_OUT,
    ACT_U_OFF, ACT_U_SQ, ACT_U_N1, ACT_U_E1, ACT_U_EXPD, ACT_U_DIFF,
    ACT_U_N2, ACT_U_E2, ACT_U_LIKE, ACT_U_WR,
    ACT_N_CHK, ACT_N_RD, ACT_N_LD, ACT_N_WR,
    ACT_R_RD, ACT_R_LD, ACT_R_FIN
  } gbsl_act_t;

  typedef struct packed {
    logic pose_valid;
    logic cell_last;
    logic exp_last;
    logic total_zero;
    logic div_busy;
  } gbsl_stat_t;

endpackage

FILE: hw/rtl/gbsl_ram.sv
// ----------------------------------------------------------------------------
// gbsl_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/gbsl_div.sv
// ----------------------------------------------------------------------------
// gbsl_div
// Restoring divider, one quotient bit per cycle, QUO_W bits.
// Needs dividend < divisor * 2^QUO_W.
// ----------------------------------------------------------------------------
module gbsl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 dividend,
  input  logic [gbsl_pkg::TOTAL_W-1:0] divisor,
  output logic                        busy,
  output logic [gbsl_pkg::QUO_W-1:0]  quot
);
  import gbsl_pkg::*;

  logic [TOTAL_W-1:0] rem;
  logic [TOTAL_W-1:0] dvs;
  logic [QUO_W-1:0]   sh;
  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W:0]   trial;
  logic               fits;

  assign trial = {rem, sh[QUO_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= TOTAL_W'(dividend[63:QUO_W]);
      sh   <= dividend[QUO_W-1:0];
      dvs  <= divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? TOTAL_W'(trial - {1'b0, dvs}) : TOTAL_W'(trial);
      sh   <= {sh[QUO_W-2:0], 1'b0};
      quot <= {quot[QUO_W-2:0], fits};
    end
  end

endmodule

FILE: hw/rtl/gbsl_ctrl.sv
// ----------------------------------------------------------------------------
// gbsl_ctrl
// Sequencer: table build after reset, per-item flow, output register valid.
// ----------------------------------------------------------------------------
module gbsl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            op,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  gbsl_pkg::gbsl_stat_t  stat,
  output gbsl_pkg::gbsl_act_t   act
);
  import gbsl_pkg::*;

  gbsl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT_WR;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    act            = ACT_NONE;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_INIT_WR: begin
        act        = ACT_INIT_WR;
        state_next = stat.exp_last ? ST_IDLE : ST_INIT_RND;
      end
      ST_INIT_RND: begin
        act        = ACT_INIT_RND;
        state_next = ST_INIT_WR;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          act = ACT_ACCEPT;
          if (op == OP_READING && stat.pose_valid) begin
            state_next = ST_U_OFF;
          end else if (op == OP_READ_CELL) begin
            state_next = ST_R_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid || out_ready) begin
          act            = ACT_LOAD_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_U_OFF:  begin act = ACT_U_OFF;  state_next = ST_U_SQ;   end
      ST_U_SQ:   begin act = ACT_U_SQ;   state_next = ST_U_N1;   end
      ST_U_N1:   begin act = ACT_U_N1;   state_next = ST_U_E1;   end
      ST_U_E1:   begin act = ACT_U_E1;   state_next = ST_U_EXPD; end
      ST_U_EXPD: begin act = ACT_U_EXPD; state_next = ST_U_DIFF; end
      ST_U_DIFF: begin act = ACT_U_DIFF; state_next = ST_U_N2;   end
      ST_U_N2:   begin act = ACT_U_N2;   state_next = ST_U_E2;   end
      ST_U_E2:   begin act = ACT_U_E2;   state_next = ST_U_LIKE; end
      ST_U_LIKE: begin act = ACT_U_LIKE; state_next = ST_U_WR;   end
      ST_U_WR: begin
        act        = ACT_U_WR;
        state_next = stat.cell_last ? ST_N_CHK : ST_U_OFF;
      end
      ST_N_CHK: begin
        act        = ACT_N_CHK;
        state_next = stat.total_zero ? ST_DONE : ST_N_RD;
      end
      ST_N_RD: begin act = ACT_N_RD; state_next = ST_N_LD;  end
      ST_N_LD: begin act = ACT_N_LD; state_next = ST_N_DIV; end
      ST_N_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_N_WR;
        end
      end
      ST_N_WR: begin
        act        = ACT_N_WR;
        state_next = stat.cell_last ? ST_DONE : ST_N_RD;
      end
      ST_R_RD: begin act = ACT_R_RD; state_next = ST_R_LD;  end
      ST_R_LD: begin act = ACT_R_LD; state_next = ST_R_DIV; end
      ST_R_DIV: begin
        if (!stat.div_busy) begin
          state_next = ST_R_FIN;
        end
      end
      ST_R_FIN: begin act = ACT_R_FIN; state_next = ST_DONE; end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/gbsl_dp.sv
// ----------------------------------------------------------------------------
// gbsl_dp
// Datapath: registers, belief and exp memories, plume and likelihood
// arithmetic, divider, result registers.
// ----------------------------------------------------------------------------
module gbsl_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  gbsl_pkg::gbsl_act_t  act,
  output gbsl_pkg::gbsl_stat_t stat,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic [1:0]           op,
  input  logic signed [15:0]   pos_x,
  input  logic signed [15:0]   pos_y,
  input  logic signed [15:0]   gas_level,
  input  logic [10:0]          cell_index,
  output logic [1:0]           status,
  output logic [6:0]           cell_value
);
  import gbsl_pkg::*;

  logic [12:0]         cell_size;
  logic [15:0]         peak_level;
  logic signed [15:0]  robot_x, robot_y;
  logic                pose_valid;
  logic [31:0]         belief_peak;
  logic signed [15:0]  z;
  logic [10:0]         idx;
  logic [1:0]          res_status;
  logic [6:0]          res_value;

  logic [DIM_W-1:0]    row, col;
  logic [EXP_AW-1:0]   k;
  logic [TOTAL_W-1:0]  total;
  logic [31:0]         best;
  logic [31:0]         e_cur;

  logic signed [OFF_W-1:0] offx, offy;
  logic [31:0]         bel;
  logic [SQ_W-1:0]     sqx, sqy;
  logic                big1, big2;
  logic [31:0]         n1q, n2q;
  logic [47:0]         eprod;
  logic [35:0]         sqd;
  logic [63:0]         prod;

  // memories
  logic                bm_we;
  logic [CELL_AW-1:0]  bm_waddr, bm_raddr;
  logic [31:0]         bm_wdata, bm_rdata;
  logic                em_we;
  logic [EXP_AW-1:0]   em_raddr;
  logic [31:0]         em_rdata;

  gbsl_ram #(.WIDTH(32), .DEPTH(CELLS)) u_belief_ram (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  gbsl_ram #(.WIDTH(32), .DEPTH(EXP_DEPTH)) u_exp_ram (
    .clk(clk), .we(em_we), .waddr(k), .wdata(e_cur),
    .raddr(em_raddr), .rdata(em_rdata)
  );

  // divider
  logic               div_start, div_busy;
  logic [63:0]        div_num;
  logic [TOTAL_W-1:0] div_den;
  logic [QUO_W-1:0]   quot;

  assign div_start = (act == ACT_N_LD) || (act == ACT_R_LD);
  assign div_num   = (act == ACT_N_LD) ? {bm_rdata, 32'd0}
                                       : 64'(bm_rdata) * 64'(VALUE_MAX);
  assign div_den   = (act == ACT_N_LD) ? total : TOTAL_W'(belief_peak);

  gbsl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .busy(div_busy), .quot(quot)
  );

  // cell geometry on doubled coordinates
  logic signed [DIM_W+1:0] colc, rowc;
  logic signed [OFF_W-1:0] cole, rowe, cse;
  logic signed [DX_W-1:0]  rx2, ry2, offxe, offye, dx, dy;
  logic signed [SQ_W-1:0]  dxe, dye;
  logic [SQ_W:0]           d2;
  logic [SQ_W-9:0]         t1;

  assign colc  = $signed({1'b0, col, 1'b0}) - $signed((DIM_W+2)'(GRID_DIM));
  assign rowc  = $signed({1'b0, row, 1'b0}) - $signed((DIM_W+2)'(GRID_DIM));
  assign cole  = OFF_W'(colc);
  assign rowe  = OFF_W'(rowc);
  assign cse   = OFF_W'($signed({1'b0, cell_size}));
  assign rx2   = DX_W'($signed({robot_x, 1'b0}));
  assign ry2   = DX_W'($signed({robot_y, 1'b0}));
  assign offxe = DX_W'(offx);
  assign offye = DX_W'(offy);
  assign dx    = rx2 - offxe;
  assign dy    = ry2 - offye;
  assign dxe   = SQ_W'(dx);
  assign dye   = SQ_W'(dy);
  assign d2    = {1'b0, sqx} + {1'b0, sqy};
  assign t1    = d2[SQ_W:9];

  // likelihood argument
  logic signed [17:0] diff;
  logic signed [35:0] diffe;
  logic [26:0]        s2;

  assign diff  = $signed({{2{z[15]}}, z}) - $signed({2'b00, eprod[47:32]});
  assign diffe = 36'(diff);
  assign s2    = sqd[35:9];

  logic [31:0] mul_a, mul_b, sat;
  logic        idx_ok;

  assign mul_a  = (act == ACT_INIT_WR) ? e_cur : bel;
  assign mul_b  = (act == ACT_INIT_WR) ? EXP_STEP[31:0] : (big2 ? 32'd0 : em_rdata);
  assign sat    = quot[QUO_W-1] ? 32'hFFFF_FFFF : quot[31:0];
  assign idx_ok = EXP_AW'(idx) < EXP_AW'(CELLS);

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = k[CELL_AW-1:0];
    bm_wdata = prod[63:32];
    bm_raddr = k[CELL_AW-1:0];
    em_we    = 1'b0;
    em_raddr = n2q[29:17];
    case (act)
      ACT_INIT_WR: begin
        em_we    = 1'b1;
        bm_we    = k < EXP_AW'(CELLS);
        bm_wdata = INIT_BELIEF;
      end
      ACT_U_E1: em_raddr = n1q[31:19];
      ACT_U_WR: bm_we = 1'b1;
      ACT_N_WR: begin
        bm_we    = 1'b1;
        bm_wdata = sat;
      end
      ACT_R_RD: bm_raddr = CELL_AW'(idx);
      default: ;
    endcase
  end

  assign stat.pose_valid = pose_valid;
  assign stat.cell_last  = k == EXP_AW'(CELLS - 1);
  assign stat.exp_last   = k == EXP_AW'(EXP_LAST);
  assign stat.total_zero = total == '0;
  assign stat.div_busy   = div_busy;

  // control-side registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size   <= 13'd128;
      peak_level  <= 16'd25600;
      robot_x     <= '0;
      robot_y     <= '0;
      pose_valid  <= 1'b0;
      belief_peak <= '0;
      k           <= '0;
      e_cur       <= EXP_FIRST;
    end else begin
      if (cfg_wr_en && cfg_index == CFG_CELL_SIZE) begin
        cell_size <= cfg_data[12:0];
      end
      if (cfg_wr_en && cfg_index == CFG_PEAK_LEVEL) begin
        peak_level <= cfg_data;
      end
      case (act)
        ACT_INIT_RND: begin
          e_cur <= 32'((prod + 64'h8000_0000) >> 32);
          k     <= k + 1'b1;
        end
        ACT_ACCEPT: begin
          k <= '0;
          if (op == OP_POSE) begin
            robot_x    <= pos_x;
            robot_y    <= pos_y;
            pose_valid <= 1'b1;
          end
        end
        ACT_U_WR: k <= stat.cell_last ? '0 : k + 1'b1;
        ACT_N_CHK: begin
          k <= '0;
          if (stat.total_zero) begin
            belief_peak <= '0;
          end
        end
        ACT_N_WR: begin
          k <= k + 1'b1;
          if (stat.cell_last) begin
            belief_peak <= (sat > best) ? sat : best;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (act)
      ACT_INIT_WR: prod <= 64'(mul_a) * 64'(mul_b);
      ACT_ACCEPT: begin
        z          <= gas_level;
        idx        <= cell_index;
        row        <= '0;
        col        <= '0;
        total      <= '0;
        res_value  <= '0;
        res_status <= (op == OP_READING && !pose_valid) ? STAT_NO_POSE : STAT_DONE;
      end
      ACT_LOAD_OUT: begin
        status     <= res_status;
        cell_value <= res_value;
      end
      ACT_U_OFF: begin
        offx <= cole * cse;
        offy <= rowe * cse;
      end
      ACT_U_SQ: begin
        bel <= bm_rdata;
        sqx <= dxe * dxe;
        sqy <= dye * dye;
      end
      ACT_U_N1: begin
        big1 <= t1 >= (SQ_W-8)'(N1_LIMIT);
        n1q  <= 32'(t1[15:0]) * N1_RECIP;
      end
      ACT_U_EXPD: eprod <= 48'(peak_level) * 48'(big1 ? 32'd0 : em_rdata);
      ACT_U_DIFF: sqd <= diffe * diffe;
      ACT_U_N2: begin
        big2 <= s2 >= 27'(N2_LIMIT);
        n2q  <= 32'(s2[14:0]) * N2_RECIP;
      end
      ACT_U_LIKE: prod <= 64'(mul_a) * 64'(mul_b);
      ACT_U_WR: begin
        total <= total + TOTAL_W'(prod[63:32]);
        if (col == DIM_W'(GRID_DIM - 1)) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      ACT_N_CHK: begin
        best <= '0;
        if (stat.total_zero) begin
          res_status <= STAT_COLLAPSED;
        end
      end
      ACT_N_WR: best <= (sat > best) ? sat : best;
      ACT_R_FIN: begin
        if (idx_ok && belief_peak != '0) begin
          res_value <= (quot > QUO_W'(VALUE_MAX)) ? VALUE_MAX : quot[6:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/grid_bayes_source_locator_top.sv
// ----------------------------------------------------------------------------
// grid_bayes_source_locator_top
// Grid Bayes filter locating a gas source with a Gaussian plume model.
//
//   port group  | flow | handshake
//   cfg_*       | in   | cfg_wr_en, no wait
//   in payload  | in   | in_valid / in_ready
//   out payload | out  | out_valid / out_ready
//
// Pose, no-op and ignored readings go from idle straight to output hand-off;
// a read takes one pass through the serial divider.
// A reading makes one pass over all cells through the shared belief and
// exp memory ports, then, unless the beliefs collapse, a second pass for
// the bit-serial normalize divide.
// After reset the exp table and uniform beliefs are built with in_ready
// low; configuration writes are taken during that sweep.
// in_ready is high only between items; a finished beat waits in the output
// register, and the next result holds in_ready low until that register frees.
// ----------------------------------------------------------------------------
module grid_bayes_source_locator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] gas_level,
  input  logic [10:0]        cell_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic [6:0]         cell_value
);
  import gbsl_pkg::*;

  gbsl_act_t  act;
  gbsl_stat_t stat;

  gbsl_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .act(act)
  );

  gbsl_dp u_dp (
    .clk(clk), .rst(rst), .act(act), .stat(stat),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .op(op), .pos_x(pos_x), .pos_y(pos_y), .gas_level(gas_level),
    .cell_index(cell_index), .status(status), .cell_value(cell_value)
  );

endmodule

FILE: hw/rtl/gbsl_checker.sv
// ----------------------------------------------------------------------------
// gbsl_checker
// Port-level checks on the result channel and in_ready, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gbsl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [6:0] cell_value
);
  import gbsl_pkg::*;

  // stalled beat holds
  `GBSL_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(status) && $stable(cell_value))
  // only a completed read carries a value
  `GBSL_ASSERT_IMP(a_value_zero, clk, rst, out_valid && status != STAT_DONE,
                   cell_value == 7'd0)
  `GBSL_ASSERT_IMP(a_value_range, clk, rst, out_valid, cell_value <= VALUE_MAX)
  `GBSL_ASSERT_IMP(a_status_code, clk, rst, out_valid,
                   status == STAT_DONE || status == STAT_NO_POSE ||
                   status == STAT_COLLAPSED)
  // nothing comes out or goes in right after reset
  `GBSL_ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !out_valid && !in_ready)

endmodule

bind grid_bayes_source_locator_top gbsl_checker u_gbsl_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .cell_value(cell_value)
);
